[src/ocd_pkg.sv]
`default_nettype none

package ocd_pkg;

    // Default arc accumulator width
    localparam int ARC_BITS_DEF = 32;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int ARC_W    = 32;
    localparam int IN_W     = 24;    // in_byte + content_length, whole bytes
    localparam int OUT_W    = 32;    // arc_value, whole bytes
    localparam int STATUS_W = 2;

    // Encoding constants
    localparam logic [7:0] CONT_BIT   = 8'h80;
    localparam logic [7:0] FIRST_DIV  = 8'd40;
    localparam logic [7:0] FIRST_DIV2 = 8'd80;

    // Result queue
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVF   = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    typedef struct packed {
        logic [ARC_W-1:0] arc_value;
        logic             last_arc;
        t_status          status;
    } t_res;

    // Up to two results per request
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_dec;

endpackage

`default_nettype wire

[src/ocd_decode.sv]
`default_nettype none

module ocd_decode #(
    parameter int ARC_BITS = ocd_pkg::ARC_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_take,
    input  wire  [ocd_pkg::BYTE_W-1:0]     i_byte,
    input  wire  [ocd_pkg::LEN_W-1:0]      i_len,
    output ocd_pkg::t_dec                  o_dec
);

    logic [ARC_BITS-1:0]         r_acc, n_acc, acc_step;
    logic [ocd_pkg::LEN_W-1:0]   r_left, n_left, left_dec, len_eff;
    logic                        r_ovf, n_ovf, sat, step_ovf;
    logic [ocd_pkg::ARC_W-1:0]   acc_out;
    logic [1:0]                  first_arc;
    logic [ocd_pkg::BYTE_W-1:0]  second_arc;

    // Would another 7-bit shift lose bits?
    assign sat      = r_ovf || (r_acc[ARC_BITS-1 -: 7] != '0);
    assign step_ovf = sat;
    assign acc_step = sat ? '1 : {r_acc[ARC_BITS-8:0], i_byte[6:0]};
    assign left_dec = r_left - 16'd1;
    assign len_eff  = (i_len == '0) ? 16'd1 : i_len;

    generate
        if (ARC_BITS >= ocd_pkg::ARC_W) begin : g_wide
            assign acc_out = acc_step[ocd_pkg::ARC_W-1:0];
        end else begin : g_narrow
            assign acc_out = {{(ocd_pkg::ARC_W-ARC_BITS){1'b0}}, acc_step};
        end
    endgenerate

    // First byte split into two arcs
    always_comb begin
        if (i_byte < ocd_pkg::FIRST_DIV) begin
            first_arc  = 2'd0;
            second_arc = i_byte;
        end else if (i_byte < ocd_pkg::FIRST_DIV2) begin
            first_arc  = 2'd1;
            second_arc = i_byte - ocd_pkg::FIRST_DIV;
        end else begin
            first_arc  = 2'd2;
            second_arc = i_byte - ocd_pkg::FIRST_DIV2;
        end
    end

    always_comb begin
        o_dec  = '0;
        n_acc  = r_acc;
        n_left = r_left;
        n_ovf  = r_ovf;
        if (i_take) begin
            if (r_left == '0) begin
                n_left = len_eff - 16'd1;
                n_acc  = '0;
                n_ovf  = 1'b0;
                o_dec.cnt          = 2'd2;
                o_dec.r0.arc_value = {30'd0, first_arc};
                o_dec.r0.last_arc  = 1'b0;
                o_dec.r0.status    = ocd_pkg::ST_OK;
                o_dec.r1.arc_value = {24'd0, second_arc};
                o_dec.r1.last_arc  = (len_eff == 16'd1);
                o_dec.r1.status    = ocd_pkg::ST_OK;
            end else begin
                n_left = left_dec;
                if ((i_byte & ocd_pkg::CONT_BIT) == '0) begin
                    o_dec.cnt          = 2'd1;
                    o_dec.r0.arc_value = acc_out;
                    o_dec.r0.last_arc  = (left_dec == '0);
                    o_dec.r0.status    = step_ovf ? ocd_pkg::ST_OVF : ocd_pkg::ST_OK;
                    n_acc = '0;
                    n_ovf = 1'b0;
                end else if (left_dec == '0) begin
                    // content ran out inside an arc
                    o_dec.cnt          = 2'd1;
                    o_dec.r0.arc_value = acc_out;
                    o_dec.r0.last_arc  = 1'b1;
                    o_dec.r0.status    = ocd_pkg::ST_TRUNC;
                    n_acc = '0;
                    n_ovf = 1'b0;
                end else begin
                    n_acc = acc_step;
                    n_ovf = step_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_left <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_left <= n_left;
            r_ovf  <= n_ovf;
        end
    end

    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && (r_left == '0) |=> (r_acc == '0) && !r_ovf)
        else $error("accumulator not cleared by first byte");

    a_left_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && (r_left != '0) |=> r_left == $past(r_left) - 16'd1)
        else $error("byte count did not step down");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dec.r0.status == ocd_pkg::ST_TRUNC) |-> o_dec.r0.last_arc && (o_dec.cnt == 2'd1))
        else $error("truncated arc not marked last");

endmodule

`default_nettype wire

[src/ocd_res_fifo.sv]
`default_nettype none

module ocd_res_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ocd_pkg::t_dec       i_dec,
    input  wire                 i_pop,
    output logic                o_valid,
    output ocd_pkg::t_res       o_head,
    output logic                o_room2
);

    localparam int D = ocd_pkg::RES_FIFO_DEPTH;

    ocd_pkg::t_res                   r_mem [D];
    logic [ocd_pkg::RES_PTR_W-1:0]   r_wp, r_rp, wp1;
    logic [ocd_pkg::RES_CNT_W-1:0]   r_count, n_count;

    assign wp1     = r_wp + 1'b1;
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign o_room2 = (r_count <= ocd_pkg::RES_CNT_W'(D - 2));
    assign n_count = r_count + ocd_pkg::RES_CNT_W'(i_dec.cnt)
                   - ocd_pkg::RES_CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_dec.cnt != 2'd0) begin
            r_mem[r_wp] <= i_dec.r0;
        end
        if (i_dec.cnt == 2'd2) begin
            r_mem[wp1] <= i_dec.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + ocd_pkg::RES_PTR_W'(i_dec.cnt);
            r_rp    <= r_rp + ocd_pkg::RES_PTR_W'(i_pop);
            r_count <= n_count;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ocd_pkg::RES_CNT_W'(D))
        else $error("result queue overfilled");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty result queue");

    a_pair_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dec.cnt == 2'd2) && !i_pop |=> r_count == $past(r_count) + 2'd2)
        else $error("pair push miscounted");

endmodule

`default_nettype wire

[src/oid_content_decoder_top.sv]
`default_nettype none

// BER object identifier content decoder. Content bytes arrive one per request
// on the slave stream, with the content byte count beside the first byte of
// each identifier (a count of zero is taken as one). The first byte gives two
// arcs (0, 1 or 2 by the standard split; bytes of 80 and up give arc 2).
// Later bytes collect 7-bit groups, most significant first, and each byte with
// its top bit clear emits one arc. Arcs wider than ARC_BITS saturate to all
// ones and carry status 1; content that ends inside an arc emits the partial
// value with status 2 and tlast. tlast marks the final arc of an identifier.
// Each continuation byte gives zero or one arc; the first byte of an
// identifier gives two arcs. A new byte is taken every cycle while the
// four-entry result queue has room for two arcs, so the master port's one
// arc per cycle (while m_axis_tready is high) is what sets the pace. A byte
// waits in the input register until the queue has room; its arcs are then
// written to the result queue and presented on the master from its head.

module oid_content_decoder_top #(
    parameter int ARC_BITS = ocd_pkg::ARC_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] in_byte, [23:8] content_length
    input  wire  [ocd_pkg::IN_W-1:0]        s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [31:0] arc_value
    output logic [ocd_pkg::OUT_W-1:0]       m_axis_tdata,
    output logic                            m_axis_tlast,
    // [1:0] status
    output logic [ocd_pkg::STATUS_W-1:0]    m_axis_tuser
);

    // input register
    logic                       r_in_valid;
    logic [ocd_pkg::IN_W-1:0]   r_in_data;
    logic                       fire, room2, pop;
    ocd_pkg::t_dec              dec;
    ocd_pkg::t_res              head;

    // decode the held byte once the queue can take both arcs of a first byte
    assign fire          = r_in_valid && room2;
    assign s_axis_tready = !r_in_valid || fire;
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
    end

    ocd_decode #(
        .ARC_BITS (ARC_BITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (fire),
        .i_byte  (r_in_data[ocd_pkg::BYTE_W-1:0]),
        .i_len   (r_in_data[ocd_pkg::BYTE_W +: ocd_pkg::LEN_W]),
        .o_dec   (dec)
    );

    ocd_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dec   (dec),
        .i_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_head  (head),
        .o_room2 (room2)
    );

    assign m_axis_tdata = head.arc_value;
    assign m_axis_tlast = head.last_arc;
    assign m_axis_tuser = head.status;

endmodule

`default_nettype wire
